>>> src/dctl_pkg.sv
// shared types, constants and helpers for the delta clock timer list
package dctl_pkg;

    // list geometry
    localparam int DEPTH   = 16;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DELTA_W = 16;
    localparam int TAG_W   = 8;
    localparam int OCC_W   = 5;
    localparam int KIND_W  = 2;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_INSERTED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL       = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NO_EXPIRY  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EXPIRED    = 2'd3;

    // input item
    typedef struct packed {
        logic               req_type;
        logic [DELTA_W-1:0] delay;
        logic [TAG_W-1:0]   event_tag;
    } cmd_t;

    // result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  expired_tag;
        logic [OCC_W-1:0]  occupancy;
        logic              last;
    } res_t;

    // one list entry as stored in memory
    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    // memory access request from the sequencer
    typedef struct packed {
        logic   we;
        ptr_t   waddr;
        entry_t wdata;
        ptr_t   raddr;
    } mem_req_t;

    // physical slot of a logical list position in the circular buffer
    function automatic ptr_t phys_addr(ptr_t base, ptr_t off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PTR_W + 1)'(DEPTH))
        begin
            sum = sum - (PTR_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // pending count shown on the occupancy field
    function automatic logic [OCC_W-1:0] occ_of(cnt_t c);
        return OCC_W'(c);
    endfunction

endpackage

>>> src/delta_clock_timer_list_top.sv
// Delta clock timer list: insert walks/shifts a circular list in one entry ram; tick pops expiries.
// Each result passes through one output register after the sequencer's strobe.
//   insert: walk, shift, place before an entry; walk, place if appended; full rejected from idle.
// Tick: empty answered from idle, nonzero head counted down, k expiries popped at one per cycle.
// One item at a time: busy falls as the last result shows, and the next item may go in then.
// Reset clears the list to empty at once; the entry ram needs no clearing pass.
module delta_clock_timer_list_top
    import dctl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic res_valid,
    output res_t res
);

    mem_req_t mem_req;
    entry_t   rd_data;
    logic     res_strobe;
    res_t     res_data;
    logic     res_valid_reg;
    res_t     res_reg;

    // sequencer
    dctl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .busy       (busy),
        .mem_req    (mem_req),
        .rd_data    (rd_data),
        .res_strobe (res_strobe),
        .res_data   (res_data)
    );

    // entry ram: delta and tag per slot
    dctl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rd_data)
    );

    // result strobe register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_strobe;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (res_strobe)
        begin
            res_reg <= res_data;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> src/dctl_ram.sv
// generic simple dual port ram with registered read
module dctl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/dctl_ctrl.sv
// sequencer: walks, shifts and pops the timer list held in the entry ram
module dctl_ctrl
    import dctl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  cmd_t     cmd,
    output logic     busy,
    output mem_req_t mem_req,
    input  entry_t   rd_data,
    output logic     res_strobe,
    output res_t     res_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WALK   = 3'd1;
    localparam logic [2:0] ST_SHIFT  = 3'd2;
    localparam logic [2:0] ST_PLACE  = 3'd3;
    localparam logic [2:0] ST_TICK   = 3'd4;
    localparam logic [2:0] ST_EXPIRE = 3'd5;
    localparam logic [2:0] ST_FLUSH  = 3'd6;

    logic [2:0]         state_reg, state_next;
    ptr_t               head_reg, head_next;
    cnt_t               count_reg, count_next;
    ptr_t               pos_reg, pos_next;
    ptr_t               j_reg, j_next;
    logic [DELTA_W-1:0] rem_reg, rem_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;

    logic               walk_more;
    logic               walk_go_on;
    ptr_t               last_ptr;
    ptr_t               rd_addr;

    // walk helpers
    assign walk_more  = rem_reg > rd_data.delta;
    assign walk_go_on = (CNT_W'(pos_reg) + CNT_W'(1)) < count_reg;
    assign last_ptr   = ptr_t'(count_reg - CNT_W'(1));

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        j_reg   <= j_next;
        rem_reg <= rem_next;
        tag_reg <= tag_next;
    end

    // read address, issued in the cycle before its data is used
    always_comb
    begin
        rd_addr = head_reg;
        unique case (state_reg) inside
            ST_WALK:
            begin
                if (walk_more)
                begin
                    rd_addr = phys_addr(head_reg, pos_reg + ptr_t'(1));
                end
                else
                begin
                    rd_addr = phys_addr(head_reg, last_ptr);
                end
            end
            ST_SHIFT:  rd_addr = phys_addr(head_reg, j_reg - ptr_t'(2));
            ST_TICK,
            ST_EXPIRE: rd_addr = phys_addr(head_reg, ptr_t'(1));
            default:   rd_addr = head_reg;
        endcase
    end

    // next state, writes and results
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        j_next        = j_reg;
        rem_next      = rem_reg;
        tag_next      = tag_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = head_reg;
        mem_req.wdata = rd_data;
        mem_req.raddr = rd_addr;
        res_strobe    = 1'b0;
        res_data      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd.req_type == REQ_INSERT)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            res_strobe         = 1'b1;
                            res_data.kind      = KIND_FULL;
                            res_data.occupancy = occ_of(count_reg);
                            res_data.last      = 1'b1;
                        end
                        else
                        begin
                            rem_next = cmd.delay;
                            tag_next = cmd.event_tag;
                            pos_next = '0;
                            if (count_reg == '0)
                            begin
                                state_next = ST_PLACE;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                            end
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_strobe         = 1'b1;
                        res_data.kind      = KIND_NO_EXPIRY;
                        res_data.occupancy = '0;
                        res_data.last      = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_TICK;
                    end
                end
            end

            // one entry compared per cycle
            ST_WALK:
            begin
                if (walk_more)
                begin
                    rem_next = rem_reg - rd_data.delta;
                    pos_next = pos_reg + ptr_t'(1);
                    if (!walk_go_on)
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    j_next     = ptr_t'(count_reg);
                    state_next = ST_SHIFT;
                end
            end

            // move entry j-1 into slot j, tail first
            ST_SHIFT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = phys_addr(head_reg, j_reg);
                mem_req.wdata = rd_data;
                if (j_reg == pos_reg + ptr_t'(1))
                begin
                    mem_req.wdata.delta = rd_data.delta - rem_reg;
                    state_next          = ST_PLACE;
                end
                else
                begin
                    j_next = j_reg - ptr_t'(1);
                end
            end

            // write the new timer into its slot
            ST_PLACE:
            begin
                mem_req.we          = 1'b1;
                mem_req.waddr       = phys_addr(head_reg, pos_reg);
                mem_req.wdata.delta = rem_reg;
                mem_req.wdata.tag   = tag_reg;
                count_next          = count_reg + CNT_W'(1);
                res_strobe          = 1'b1;
                res_data.kind       = KIND_INSERTED;
                res_data.occupancy  = occ_of(count_reg + CNT_W'(1));
                res_data.last       = 1'b1;
                state_next          = ST_IDLE;
            end

            // head examined: count down or start popping
            ST_TICK:
            begin
                if (rd_data.delta != '0)
                begin
                    mem_req.we          = 1'b1;
                    mem_req.waddr       = head_reg;
                    mem_req.wdata.delta = rd_data.delta - DELTA_W'(1);
                    res_strobe          = 1'b1;
                    res_data.kind       = KIND_NO_EXPIRY;
                    res_data.occupancy  = occ_of(count_reg);
                    res_data.last       = 1'b1;
                    state_next          = ST_IDLE;
                end
                else
                begin
                    tag_next   = rd_data.tag;
                    head_next  = phys_addr(head_reg, ptr_t'(1));
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg > CNT_W'(1))
                    begin
                        state_next = ST_EXPIRE;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            // report the popped tag once the next head shows whether it is last
            ST_EXPIRE:
            begin
                res_strobe           = 1'b1;
                res_data.kind        = KIND_EXPIRED;
                res_data.expired_tag = tag_reg;
                res_data.occupancy   = occ_of(count_reg);
                res_data.last        = (rd_data.delta != '0);
                if (rd_data.delta == '0)
                begin
                    tag_next   = rd_data.tag;
                    head_next  = phys_addr(head_reg, ptr_t'(1));
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg <= CNT_W'(1))
                    begin
                        state_next = ST_FLUSH;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            // list emptied: final expired item
            ST_FLUSH:
            begin
                res_strobe           = 1'b1;
                res_data.kind        = KIND_EXPIRED;
                res_data.expired_tag = tag_reg;
                res_data.occupancy   = occ_of(count_reg);
                res_data.last        = 1'b1;
                state_next           = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("pending count above list depth");

    a_walk_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK || state_reg == ST_SHIFT) |-> !res_strobe)
        else $error("result issued in the middle of an insert");

    a_shift_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (mem_req.waddr != mem_req.raddr))
        else $error("shift writes the slot it is reading");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (res_strobe && res_data.kind == KIND_INSERTED)
            |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list by one");

    a_empty_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && start && cmd.req_type == REQ_TICK && count_reg == '0)
            |-> (res_strobe && res_data.last))
        else $error("tick on empty list gave no immediate item");
`endif

endmodule

>>> verif/tb_delta_clock_timer_list_top.sv
// self-checking testbench for the delta clock timer list, directed table then random episodes
module tb_delta_clock_timer_list_top;
    import dctl_pkg::*;

    // one row of the directed table: the item and, where obvious, its single result
    typedef struct packed {
        cmd_t c;
        logic typed;
        res_t want;
    } dir_row_t;

    localparam int DIR_ROWS   = 25;
    localparam int RAND_ITEMS = 320;
    localparam int SETTLE     = 2 * DEPTH + 8;

    logic clk;
    logic rst_n;
    logic start;
    cmd_t cmd;
    logic busy;
    logic res_valid;
    res_t res;

    // typed result riding along with the item on the ports
    logic typed_valid;
    res_t typed_value;

    // timer list as the testbench expects it
    logic [DELTA_W-1:0] list_delta [DEPTH];
    logic [TAG_W-1:0]   list_tag   [DEPTH];
    int                 list_count;

    // results still owed by the block, oldest first
    res_t due_results [$];

    dir_row_t dir_rows [DIR_ROWS];

    int errors;
    int items_sent;
    int results_seen;
    int full_rejects;
    int expiry_bursts;
    int max_burst;

    delta_clock_timer_list_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .res_valid(res_valid),
        .res      (res)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #2000000;
        $display("TIMEOUT at %0t", $time);
        $display("Mismatches found");
        $finish;
    end

    // apply one item to the expected list and queue the results it causes
    task automatic timer_list_apply(input cmd_t c);
        int pos;
        int j;
        int burst;
        logic [DELTA_W-1:0] left;
        res_t r;
        r = '0;
        r.last = 1'b1;
        if (c.req_type == REQ_INSERT)
        begin
            if (list_count >= DEPTH)
            begin
                r.kind = KIND_FULL;
                full_rejects++;
            end
            else
            begin
                // walk past entries whose delta the new delay exceeds
                pos = 0;
                left = c.delay;
                while (pos < list_count && left > list_delta[pos])
                begin
                    left = left - list_delta[pos];
                    pos++;
                end
                // open a slot and shorten the successor
                for (j = list_count; j > pos; j--)
                begin
                    list_delta[j] = list_delta[j-1];
                    list_tag[j]   = list_tag[j-1];
                end
                list_delta[pos] = left;
                list_tag[pos]   = c.event_tag;
                list_count++;
                if (pos + 1 < list_count)
                    list_delta[pos+1] = list_delta[pos+1] - left;
                r.kind = KIND_INSERTED;
            end
            r.occupancy = OCC_W'(list_count);
            due_results.push_back(r);
        end
        else if (list_count == 0 || list_delta[0] != '0)
        begin
            if (list_count != 0)
                list_delta[0] = list_delta[0] - 1'b1;
            r.kind = KIND_NO_EXPIRY;
            r.occupancy = OCC_W'(list_count);
            due_results.push_back(r);
        end
        else
        begin
            // pop every leading zero-delta entry, one result each
            burst = 0;
            while (list_count > 0 && list_delta[0] == '0)
            begin
                r.kind = KIND_EXPIRED;
                r.expired_tag = list_tag[0];
                for (j = 0; j + 1 < list_count; j++)
                begin
                    list_delta[j] = list_delta[j+1];
                    list_tag[j]   = list_tag[j+1];
                end
                list_count--;
                r.occupancy = OCC_W'(list_count);
                r.last = !(list_count > 0 && list_delta[0] == '0);
                due_results.push_back(r);
                burst++;
            end
            expiry_bursts++;
            if (burst > max_burst)
                max_burst = burst;
        end
    endtask

    task automatic mismatch(input string field, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    // check results and track accepted items
    always @(posedge clk)
    begin : watch_ports
        res_t want;
        int n_before;
        if (rst_n)
        begin
            if (res_valid)
            begin
                results_seen++;
                if (due_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %h", $time, res);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (res.kind !== want.kind)
                        mismatch("kind", want.kind, res.kind);
                    if (res.expired_tag !== want.expired_tag)
                        mismatch("expired_tag", want.expired_tag, res.expired_tag);
                    if (res.occupancy !== want.occupancy)
                        mismatch("occupancy", want.occupancy, res.occupancy);
                    if (res.last !== want.last)
                        mismatch("last", want.last, res.last);
                end
            end
            if (start && !busy)
            begin
                n_before = due_results.size();
                timer_list_apply(cmd);
                if (typed_valid && due_results.size() == n_before + 1)
                    due_results[n_before] = typed_value;
            end
        end
    end

    function automatic dir_row_t row_insert(input int d, input int t);
        dir_row_t row;
        row = '0;
        row.c.req_type  = REQ_INSERT;
        row.c.delay     = DELTA_W'(d);
        row.c.event_tag = TAG_W'(t);
        return row;
    endfunction

    function automatic dir_row_t row_tick();
        dir_row_t row;
        row = '0;
        row.c.req_type = REQ_TICK;
        return row;
    endfunction

    function automatic dir_row_t with_result(input dir_row_t row, input logic [KIND_W-1:0] k,
                                             input int t, input int occ);
        row.typed = 1'b1;
        row.want.kind        = k;
        row.want.expired_tag = TAG_W'(t);
        row.want.occupancy   = OCC_W'(occ);
        row.want.last        = 1'b1;
        return row;
    endfunction

    function automatic int pick_gap(input bit quiet);
        if (quiet)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    // present one item and wait until the block takes it
    task automatic issue_cmd(input cmd_t c, input logic has_typed, input res_t typed_res,
                             input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        cmd         <= c;
        typed_valid <= has_typed;
        typed_value <= typed_res;
        do
            @(posedge clk);
        while (!(start && !busy));
        items_sent++;
    endtask

    task automatic send_insert(input int d, input bit quiet);
        cmd_t c;
        c.req_type  = REQ_INSERT;
        c.delay     = DELTA_W'(d);
        c.event_tag = TAG_W'($urandom_range(0, 255));
        issue_cmd(c, 1'b0, '0, pick_gap(quiet));
    endtask

    // delay and tag are don't-care on a tick, so they are randomized too
    task automatic send_tick(input bit quiet);
        cmd_t c;
        c.req_type  = REQ_TICK;
        c.delay     = DELTA_W'($urandom_range(0, 65535));
        c.event_tag = TAG_W'($urandom_range(0, 255));
        issue_cmd(c, 1'b0, '0, pick_gap(quiet));
    endtask

    // delay for a mixed episode: mostly short, some deeper walks, rarely anything
    function automatic int mixed_delay();
        int p;
        p = $urandom_range(0, 99);
        if (p == 0)
            return $urandom_range(0, 65535);
        if (p < 15)
            return $urandom_range(6, 40);
        return $urandom_range(0, 5);
    endfunction

    initial
    begin
        int i;
        int k;
        int d;
        int episode;
        int rand_items;
        bit quiet;

        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        typed_valid = 1'b0;
        typed_value = '0;
        list_count  = 0;
        errors      = 0;
        items_sent  = 0;
        results_seen  = 0;
        full_rejects  = 0;
        expiry_bursts = 0;
        max_burst     = 0;
        for (i = 0; i < DEPTH; i++)
        begin
            list_delta[i] = '0;
            list_tag[i]   = '0;
        end

        // directed items: empty tick, zero and maximum delay, equal delays, fill to full
        dir_rows = '{
            with_result(row_tick(), KIND_NO_EXPIRY, 0, 0),
            with_result(row_insert(0, 8'hFF), KIND_INSERTED, 0, 1),
            with_result(row_tick(), KIND_EXPIRED, 8'hFF, 0),
            with_result(row_insert(16'hFFFF, 8'h00), KIND_INSERTED, 0, 1),
            with_result(row_tick(), KIND_NO_EXPIRY, 0, 1),
            row_insert(3, 8'h11),
            row_insert(3, 8'h22),
            row_insert(0, 8'h33),
            row_insert(1, 8'h44),
            row_tick(),
            row_insert(0, 8'h5A),
            row_insert(1, 8'hA5),
            row_insert(2, 8'h0F),
            row_insert(4, 8'hF0),
            row_insert(7, 8'h80),
            row_insert(8, 8'h01),
            row_insert(0, 8'h7E),
            row_insert(3, 8'hC3),
            row_insert(5, 8'h3C),
            row_insert(6, 8'h96),
            row_insert(1, 8'h69),
            row_insert(2, 8'hE7),
            with_result(row_insert(9, 8'h42), KIND_FULL, 0, DEPTH),
            row_tick(),
            row_tick()
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
            issue_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want, pick_gap(1'b0));

        // random episodes: mixed traffic, drains, and fill-then-expire bursts
        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            episode = $urandom_range(0, 3);
            quiet = ($urandom_range(0, 3) == 0);
            if (episode < 2)
            begin
                for (k = 0; k < 16; k++)
                begin
                    if ($urandom_range(0, 1))
                        send_tick(quiet);
                    else
                        send_insert(mixed_delay(), quiet);
                end
                rand_items += 16;
            end
            else if (episode == 2)
            begin
                for (k = 0; k < 12; k++)
                    send_tick(quiet);
                rand_items += 12;
            end
            else
            begin
                // drain, pack the list with one shared delay, then tick until it all expires
                d = $urandom_range(0, 2);
                for (k = 0; k < 12; k++)
                    send_tick(quiet);
                for (k = 0; k < DEPTH + 2; k++)
                    send_insert(d, quiet);
                for (k = 0; k <= d; k++)
                    send_tick(quiet);
                rand_items += 12 + DEPTH + 2 + d + 1;
            end
        end
        start <= 1'b0;

        // wait for the owed results, then let the block go quiet
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d items (%0d directed); checked %0d results", items_sent, DIR_ROWS,
                 results_seen);
        $display("Full-list rejects %0d, expiring ticks %0d, largest expiry burst %0d",
                 full_rejects, expiry_bursts, max_burst);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
